[design/assert_macros.svh]
// Assertion macros used by the encoder controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PTME_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define PTME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTME_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTME_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/ptme_pkg.sv]
// Shared types, codes and helpers of the palette tile encoder.
package ptme_pkg;

    localparam int WORD_W        = 25;
    localparam int SCALAR_W      = 32;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int DIM_W         = 7;
    localparam int IDX_W         = 4;
    localparam int DCNT_W        = 5;
    localparam int PALETTE_LIMIT = 16;

    localparam int P95_BIT  = 17;
    localparam int SUP_BIT  = 18;
    localparam int BND_BIT  = 19;
    localparam int UNIT_BIT = 24;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_COUNT    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] MODE_UNIFORM = 2'd0;
    localparam logic [1:0] MODE_TWO     = 2'd1;
    localparam logic [1:0] MODE_FOUR    = 2'd2;
    localparam logic [1:0] MODE_DENSE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_H = 2'd3;

    localparam logic [7:0] MAGIC_0 = 8'h4f;
    localparam logic [7:0] MAGIC_1 = 8'h53;
    localparam logic [7:0] MAGIC_2 = 8'h46;
    localparam logic [7:0] MAGIC_3 = 8'h35;
    localparam logic [7:0] VERSION = 8'd1;

    typedef struct packed {
        logic load;
        logic rd;
        logic fmt;
    } ctl_cmd_t;

    typedef struct packed {
        logic emitting;
    } dp_sts_t;

    function automatic logic [7:0] pick_byte(input logic [31:0] v, input logic [1:0] k);
        return v[8*k +: 8];
    endfunction

endpackage

[design/ptme_if.sv]
// Input and output channel interfaces of the palette tile encoder.
interface ptme_in_if;
    import ptme_pkg::*;
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [WORD_W-1:0]   class_word;
    logic [SCALAR_W-1:0] p95_bits;
    logic [SCALAR_W-1:0] support_bits;
    logic [SCALAR_W-1:0] bound_bits;
    modport source (output valid, opcode, class_word, p95_bits, support_bits, bound_bits,
                    input ready);
    modport sink (input valid, opcode, class_word, p95_bits, support_bits, bound_bits,
                  output ready);
endinterface

interface ptme_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    logic [1:0] status;
    logic [1:0] mode;
    modport source (output valid, out_byte, last_byte, status, mode, input ready);
    modport sink (input valid, out_byte, last_byte, status, mode, output ready);
endinterface

[design/ptme_ctrl.sv]
// Handshake controller of the palette tile encoder.
`include "assert_macros.svh"
module ptme_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_opcode,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ptme_pkg::ctl_cmd_t  cmd,
    input  ptme_pkg::dp_sts_t   sts
);
    import ptme_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_FMT  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd.load = in_ready && in_valid && (in_opcode == OP_LOAD) && !sts.emitting;
        cmd.rd   = (state_reg == S_RD);
        cmd.fmt  = (state_reg == S_FMT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (in_opcode == OP_FETCH))
                    state_next = S_RD;
            end
            S_RD:  state_next = S_FMT;
            S_FMT: state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `PTME_ASSERT(a_no_accept_while_full, clk, rst_n, out_valid |-> !in_ready, "input taken while a beat waits")
    `PTME_ASSERT(a_rd_then_fmt, clk, rst_n, cmd.rd |=> cmd.fmt, "read not followed by format")
    `PTME_ASSERT(a_fmt_then_out, clk, rst_n, cmd.fmt |=> out_valid, "format not followed by beat")
    `PTME_ASSERT_ALWAYS(a_load_not_emitting, clk, cmd.load |-> !sts.emitting, "load during stream")
endmodule

[design/ptme_datapath.sv]
// Record stores, palette and byte formatter of the palette tile encoder.
module ptme_datapath #(
    parameter int MAX_EDGE = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptme_pkg::ctl_cmd_t                  cmd,
    output ptme_pkg::dp_sts_t                   sts,
    input  logic                                cfg_we,
    input  logic [ptme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptme_pkg::CFG_W-1:0]          cfg_data,
    input  logic [ptme_pkg::WORD_W-1:0]         class_word,
    input  logic [ptme_pkg::SCALAR_W-1:0]       p95_bits,
    input  logic [ptme_pkg::SCALAR_W-1:0]       support_bits,
    input  logic [ptme_pkg::SCALAR_W-1:0]       bound_bits,
    output logic [7:0]                          out_byte,
    output logic                                last_byte,
    output logic [1:0]                          status,
    output logic [1:0]                          mode
);
    import ptme_pkg::*;

    localparam int CAP  = MAX_EDGE * MAX_EDGE * 3;
    localparam int AW   = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int RCW  = $clog2(CAP + 1);
    localparam int ROWS = (CAP + 3) / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LW   = (RCW + 2 > 7) ? RCW + 2 : 7;

    typedef enum logic [2:0] {
        SEC_HDR  = 3'd0,
        SEC_HW   = 3'd1,
        SEC_PAL  = 3'd2,
        SEC_BODY = 3'd3,
        SEC_P95  = 3'd4,
        SEC_SUP  = 3'd5,
        SEC_BND  = 3'd6
    } sec_t;

    // configuration
    logic [CFG_W-1:0] tile_x_reg, tile_y_reg;
    logic [DIM_W-1:0] tile_w_reg, tile_h_reg;

    // tile control state
    logic [RCW-1:0]    rc_reg, p95c_reg, supc_reg, bndc_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              ovf_reg, emit_reg;
    sec_t              sec_reg;
    logic [LW-1:0]     off_reg;

    // storage
    logic [WORD_W-1:0]   palette_reg [PALETTE_LIMIT];
    logic [WORD_W-1:0]   word_mem [CAP];
    logic [SCALAR_W-1:0] p95_mem [CAP];
    logic [SCALAR_W-1:0] sup_mem [CAP];
    logic [SCALAR_W-1:0] bnd_mem [CAP];
    logic [IDX_W-1:0]    idx_mem [4][ROWS];

    logic [WORD_W-1:0]   word_q;
    logic [SCALAR_W-1:0] p95_q, sup_q, bnd_q;
    logic [IDX_W-1:0]    idx_q [4];

    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic [1:0] status_reg, mode_reg;

    assign sts.emitting = emit_reg;
    assign out_byte     = out_byte_reg;
    assign last_byte    = last_reg;
    assign status       = status_reg;
    assign mode         = mode_reg;

    // palette lookup
    logic [DCNT_W-1:0] used;
    logic [PALETTE_LIMIT-1:0] hit;
    logic [IDX_W-1:0] hit_idx, new_idx;
    logic found, full, pal_room;
    logic [WORD_W-1:0] w;

    assign w        = class_word;
    assign used     = (dcnt_reg > DCNT_W'(PALETTE_LIMIT)) ? DCNT_W'(PALETTE_LIMIT) : dcnt_reg;
    assign full     = (rc_reg == RCW'(CAP));
    assign pal_room = (dcnt_reg < DCNT_W'(PALETTE_LIMIT));

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < PALETTE_LIMIT; i++)
            hit[i] = (DCNT_W'(i) < used) && (palette_reg[i] == w);
        for (int i = PALETTE_LIMIT - 1; i >= 0; i--)
            if (hit[i])
                hit_idx = IDX_W'(i);
        found   = |hit;
        new_idx = found ? hit_idx : (pal_room ? dcnt_reg[IDX_W-1:0] : '0);
    end

    // mode and stream section lengths
    logic [1:0] mode_code;
    logic [LW-1:0] sec_len [7];

    always_comb
    begin
        if (dcnt_reg == DCNT_W'(1))
            mode_code = MODE_UNIFORM;
        else if (dcnt_reg <= DCNT_W'(4))
            mode_code = MODE_TWO;
        else if (dcnt_reg <= DCNT_W'(PALETTE_LIMIT))
            mode_code = MODE_FOUR;
        else
            mode_code = MODE_DENSE;
    end

    always_comb
    begin
        sec_len[SEC_HDR] = LW'(8);
        sec_len[SEC_HW]  = LW'(32);
        sec_len[SEC_PAL] = (mode_code == MODE_DENSE) ? '0 : LW'({dcnt_reg, 2'b00});
        case (mode_code)
            MODE_UNIFORM: sec_len[SEC_BODY] = '0;
            MODE_TWO:     sec_len[SEC_BODY] = LW'((LW'(rc_reg) + LW'(3)) >> 2);
            MODE_FOUR:    sec_len[SEC_BODY] = LW'((LW'(rc_reg) + LW'(1)) >> 1);
            default:      sec_len[SEC_BODY] = LW'({rc_reg, 2'b00});
        endcase
        sec_len[SEC_P95] = LW'({p95c_reg, 2'b00});
        sec_len[SEC_SUP] = LW'({supc_reg, 2'b00});
        sec_len[SEC_BND] = LW'({bndc_reg, 2'b00});
    end

    // next non-empty section
    sec_t nxt_sec;
    logic has_nxt, at_end, is_last;

    always_comb
    begin
        nxt_sec = SEC_HDR;
        has_nxt = 1'b0;
        for (int j = 6; j >= 0; j--)
        begin
            if ((j > int'(sec_reg)) && (sec_len[j] != '0))
            begin
                nxt_sec = sec_t'(3'(j));
                has_nxt = 1'b1;
            end
        end
        at_end  = ((off_reg + LW'(1)) == sec_len[sec_reg]);
        is_last = at_end && !has_nxt;
    end

    // tile check on the first fetch
    logic [13:0] area;
    logic [15:0] need_cnt;
    logic [1:0]  chk_status;

    always_comb
    begin
        area     = 14'(tile_w_reg) * 14'(tile_h_reg);
        need_cnt = {1'b0, area, 1'b0} + {2'b00, area};
        if (ovf_reg)
            chk_status = ST_OVERFLOW;
        else if ((tile_w_reg == '0) || (tile_h_reg == '0) || (32'(rc_reg) != 32'(need_cnt)))
            chk_status = ST_COUNT;
        else
            chk_status = ST_OK;
    end

    // byte formatter
    logic [AW-1:0] waddr;
    logic [RW-1:0] raddr;
    logic [7:0]    body_byte, cur_byte;

    assign waddr = AW'(off_reg >> 2);
    assign raddr = (mode_code == MODE_TWO) ? RW'(off_reg) : RW'(off_reg >> 1);

    always_comb
    begin
        body_byte = '0;
        case (mode_code)
            MODE_TWO:
            begin
                for (int k = 0; k < 4; k++)
                    if ({off_reg, 2'(k)} < (LW + 2)'(rc_reg))
                        body_byte[2*k +: 2] = idx_q[k][1:0];
            end
            MODE_FOUR:
            begin
                body_byte[3:0] = off_reg[0] ? idx_q[2] : idx_q[0];
                if ({off_reg, 1'b1} < (LW + 1)'(rc_reg))
                    body_byte[7:4] = off_reg[0] ? idx_q[3] : idx_q[1];
            end
            default: body_byte = pick_byte(32'(word_q), off_reg[1:0]);
        endcase
    end

    always_comb
    begin
        cur_byte = '0;
        case (sec_reg)
            SEC_HDR:
            begin
                case (off_reg[2:0])
                    3'd0:    cur_byte = MAGIC_0;
                    3'd1:    cur_byte = MAGIC_1;
                    3'd2:    cur_byte = MAGIC_2;
                    3'd3:    cur_byte = MAGIC_3;
                    3'd4:    cur_byte = VERSION;
                    3'd5:    cur_byte = 8'(mode_code) + 8'd1;
                    3'd6:    cur_byte = (mode_code == MODE_DENSE) ? '0 : 8'(dcnt_reg);
                    default: cur_byte = '0;
                endcase
            end
            SEC_HW:
            begin
                case (off_reg[4:2])
                    3'd0:    cur_byte = pick_byte(tile_x_reg, off_reg[1:0]);
                    3'd1:    cur_byte = pick_byte(tile_y_reg, off_reg[1:0]);
                    3'd2:    cur_byte = pick_byte(32'(tile_w_reg), off_reg[1:0]);
                    3'd3:    cur_byte = pick_byte(32'(tile_h_reg), off_reg[1:0]);
                    3'd4:    cur_byte = pick_byte(32'(rc_reg), off_reg[1:0]);
                    3'd5:    cur_byte = pick_byte(32'(p95c_reg), off_reg[1:0]);
                    3'd6:    cur_byte = pick_byte(32'(supc_reg), off_reg[1:0]);
                    default: cur_byte = pick_byte(32'(bndc_reg), off_reg[1:0]);
                endcase
            end
            SEC_PAL:  cur_byte = pick_byte(32'(palette_reg[off_reg[5:2]]), off_reg[1:0]);
            SEC_BODY: cur_byte = body_byte;
            SEC_P95:  cur_byte = pick_byte(p95_q, off_reg[1:0]);
            SEC_SUP:  cur_byte = pick_byte(sup_q, off_reg[1:0]);
            default:  cur_byte = pick_byte(bnd_q, off_reg[1:0]);
        endcase
    end

    logic do_store, err_out;
    assign do_store = cmd.load && !full;
    assign err_out  = cmd.fmt && !emit_reg && (chk_status != ST_OK);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_x_reg <= '0;
            tile_y_reg <= '0;
            tile_w_reg <= DIM_W'(64);
            tile_h_reg <= DIM_W'(64);
            rc_reg     <= '0;
            p95c_reg   <= '0;
            supc_reg   <= '0;
            bndc_reg   <= '0;
            dcnt_reg   <= '0;
            ovf_reg    <= 1'b0;
            emit_reg   <= 1'b0;
            sec_reg    <= SEC_HDR;
            off_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TILE_X: tile_x_reg <= cfg_data;
                    REG_TILE_Y: tile_y_reg <= cfg_data;
                    REG_TILE_W: tile_w_reg <= cfg_data[DIM_W-1:0];
                    REG_TILE_H: tile_h_reg <= cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load && full)
                ovf_reg <= 1'b1;
            if (do_store)
            begin
                rc_reg <= rc_reg + RCW'(1);
                if (!found)
                    dcnt_reg <= pal_room ? dcnt_reg + DCNT_W'(1) : DCNT_W'(PALETTE_LIMIT + 1);
                if (w[P95_BIT])
                    p95c_reg <= p95c_reg + RCW'(1);
                if (w[SUP_BIT] && !w[UNIT_BIT])
                    supc_reg <= supc_reg + RCW'(1);
                if (w[BND_BIT])
                    bndc_reg <= bndc_reg + RCW'(1);
            end
            if (cmd.fmt)
            begin
                if (err_out || is_last)
                begin
                    // drop the tile and start loading again
                    rc_reg   <= '0;
                    p95c_reg <= '0;
                    supc_reg <= '0;
                    bndc_reg <= '0;
                    dcnt_reg <= '0;
                    ovf_reg  <= 1'b0;
                    emit_reg <= 1'b0;
                    sec_reg  <= SEC_HDR;
                    off_reg  <= '0;
                end
                else
                begin
                    emit_reg <= 1'b1;
                    if (at_end)
                    begin
                        sec_reg <= nxt_sec;
                        off_reg <= '0;
                    end
                    else
                        off_reg <= off_reg + LW'(1);
                end
            end
        end
    end

    // stores, palette and result payload
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            word_mem[AW'(rc_reg)] <= w;
            idx_mem[rc_reg[1:0]][RW'(rc_reg >> 2)] <= new_idx;
            if (!found && pal_room)
                palette_reg[dcnt_reg[IDX_W-1:0]] <= w;
            if (w[P95_BIT])
                p95_mem[AW'(p95c_reg)] <= p95_bits;
            if (w[SUP_BIT] && !w[UNIT_BIT])
                sup_mem[AW'(supc_reg)] <= support_bits;
            if (w[BND_BIT])
                bnd_mem[AW'(bndc_reg)] <= bound_bits;
        end
        if (cmd.rd)
        begin
            word_q <= word_mem[waddr];
            p95_q  <= p95_mem[waddr];
            sup_q  <= sup_mem[waddr];
            bnd_q  <= bnd_mem[waddr];
            for (int l = 0; l < 4; l++)
                idx_q[l] <= idx_mem[l][raddr];
        end
        if (cmd.fmt)
        begin
            if (err_out)
            begin
                out_byte_reg <= '0;
                last_reg     <= 1'b1;
                status_reg   <= chk_status;
                mode_reg     <= MODE_UNIFORM;
            end
            else
            begin
                out_byte_reg <= cur_byte;
                last_reg     <= is_last;
                status_reg   <= ST_OK;
                mode_reg     <= mode_code;
            end
        end
    end
endmodule

[design/palette_tile_metadata_encoder_unit.sv]
// Top level of the palette tile metadata encoder.
//
// Usage: records of one tile arrive on in_ch with opcode load, one beat per
// cycle; each is folded into a 16-entry palette, a per-record palette index and
// compact scalar queues. Beats with opcode fetch then pull the encoded tile out
// one byte per beat on out_ch: magic, version, mode, palette count, eight
// header words, palette, packed indices or dense words, then p95, support and
// bound scalars. last_byte flags the final byte, after which the tile state
// clears and loading starts again. The first fetch checks the record count
// against tile_width*tile_height*3 and reports a mismatch or overflow as a
// single error beat with last_byte set.
// Flow: load beats are absorbed back to back while the controller is idle. A
// fetch reads the record memories, formats the byte and presents the result
// beat through the controller's idle, read, format and present steps, and no
// new beat is accepted until that result beat is taken.
// Reset: asynchronous, active low; the tile is empty and control registers take
// reset values, memories and result payload are not reset, no clearing pass is
// needed. While out_ch is stalled the result beat holds, in_ch stays not ready.
module palette_tile_metadata_encoder_unit #(
    parameter int MAX_EDGE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ptme_in_if.sink                         in_ch,
    ptme_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [ptme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptme_pkg::CFG_W-1:0]      cfg_data
);
    import ptme_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    // sequence loads and fetches, hold the result beat until taken
    ptme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // stores, palette, counters and byte formatter
    ptme_datapath #(
        .MAX_EDGE (MAX_EDGE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .class_word   (in_ch.class_word),
        .p95_bits     (in_ch.p95_bits),
        .support_bits (in_ch.support_bits),
        .bound_bits   (in_ch.bound_bits),
        .out_byte     (out_ch.out_byte),
        .last_byte    (out_ch.last_byte),
        .status       (out_ch.status),
        .mode         (out_ch.mode)
    );
endmodule

[tb/tb_top.sv]
// Self-checking testbench of the palette tile encoder: loads, byte fetches and errors.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ptme_pkg::*;

    // Tile store depth of the block at its default edge of 64.
    localparam int TILE_EDGE  = 64;
    localparam int STORE_CAP  = TILE_EDGE * TILE_EDGE * 3;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 300;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
        logic [1:0] mode;
    } tile_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    ptme_in_if  in_bus();
    ptme_out_if out_bus();

    palette_tile_metadata_encoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_bus),
        .out_ch    (out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the encoder state, updated on every accepted beat.
    logic [WORD_W-1:0]   word_mem [STORE_CAP];
    logic [IDX_W-1:0]    index_mem [STORE_CAP];
    logic [SCALAR_W-1:0] p95_mem [STORE_CAP];
    logic [SCALAR_W-1:0] support_mem [STORE_CAP];
    logic [SCALAR_W-1:0] bound_mem [STORE_CAP];
    logic [WORD_W-1:0]   palette_mem [PALETTE_LIMIT];
    int unsigned distinct_cnt, rec_cnt, p95_cnt, support_cnt, bound_cnt, emit_pos;
    bit          overflowed, streaming;
    logic [31:0] reg_x, reg_y;
    logic [6:0]  reg_w, reg_h;

    tile_beat_t expected_beats[$];

    int  fail_count;
    int  beats_checked;
    int  tiles_done;
    int  errors_seen;
    int  ignored_loads;
    int  stall_count;
    int  items_sent;
    bit  hold_req;
    bit  no_gaps;

    // ---------------------------------------------------------------
    // Shadow encoder
    // ---------------------------------------------------------------
    function automatic void clear_shadow_tile();
        distinct_cnt = 0;
        rec_cnt      = 0;
        p95_cnt      = 0;
        support_cnt  = 0;
        bound_cnt    = 0;
        emit_pos     = 0;
        overflowed   = 0;
        streaming    = 0;
    endfunction

    function automatic logic [1:0] shadow_mode();
        if (distinct_cnt == 1)
            return MODE_UNIFORM;
        if (distinct_cnt <= 4)
            return MODE_TWO;
        if (distinct_cnt <= PALETTE_LIMIT)
            return MODE_FOUR;
        return MODE_DENSE;
    endfunction

    function automatic logic [7:0] lane_of(logic [31:0] v, int unsigned pos);
        return 8'(v >> (8 * (pos % 4)));
    endfunction

    function automatic int unsigned palette_len();
        return (shadow_mode() == MODE_DENSE) ? 0 : distinct_cnt * 4;
    endfunction

    function automatic int unsigned body_len();
        case (shadow_mode())
            MODE_UNIFORM: return 0;
            MODE_TWO:     return (rec_cnt + 3) / 4;
            MODE_FOUR:    return (rec_cnt + 1) / 2;
            default:      return rec_cnt * 4;
        endcase
    endfunction

    function automatic int unsigned tile_stream_len();
        return 40 + palette_len() + body_len() + 4 * (p95_cnt + support_cnt + bound_cnt);
    endfunction

    function automatic logic [7:0] tile_stream_byte(int unsigned pos);
        logic [1:0]  m;
        logic [31:0] hdr;
        logic [7:0]  packed_idx;
        int unsigned n;
        int unsigned i;
        m = shadow_mode();
        if (pos < 8)
        begin
            case (pos)
                0: return MAGIC_0;
                1: return MAGIC_1;
                2: return MAGIC_2;
                3: return MAGIC_3;
                4: return VERSION;
                5: return m + 8'd1;
                6: return (m == MODE_DENSE) ? 8'd0 : 8'(distinct_cnt);
                default: return 8'd0;
            endcase
        end
        pos -= 8;
        if (pos < 32)
        begin
            case (pos / 4)
                0: hdr = reg_x;
                1: hdr = reg_y;
                2: hdr = 32'(reg_w);
                3: hdr = 32'(reg_h);
                4: hdr = rec_cnt;
                5: hdr = p95_cnt;
                6: hdr = support_cnt;
                default: hdr = bound_cnt;
            endcase
            return lane_of(hdr, pos);
        end
        pos -= 32;
        n = palette_len();
        if (pos < n)
            return lane_of(32'(palette_mem[pos / 4]), pos);
        pos -= n;
        n = body_len();
        if (pos < n)
        begin
            packed_idx = 8'd0;
            if (m == MODE_TWO)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    i = pos * 4 + k;
                    if (i < rec_cnt)
                        packed_idx |= 8'(index_mem[i][1:0]) << (2 * k);
                end
                return packed_idx;
            end
            if (m == MODE_FOUR)
            begin
                i = pos * 2;
                packed_idx = 8'(index_mem[i]);
                if (i + 1 < rec_cnt)
                    packed_idx |= 8'(index_mem[i + 1]) << 4;
                return packed_idx;
            end
            return lane_of(32'(word_mem[pos / 4]), pos);
        end
        pos -= n;
        if (pos < 4 * p95_cnt)
            return lane_of(p95_mem[pos / 4], pos);
        pos -= 4 * p95_cnt;
        if (pos < 4 * support_cnt)
            return lane_of(support_mem[pos / 4], pos);
        pos -= 4 * support_cnt;
        if (pos < 4 * bound_cnt)
            return lane_of(bound_mem[pos / 4], pos);
        return 8'd0;
    endfunction

    function automatic void absorb_record(logic [WORD_W-1:0] w, logic [31:0] p95,
                                          logic [31:0] sup, logic [31:0] bnd);
        int unsigned used;
        int unsigned slot;
        bit          hit;
        if (streaming)
        begin
            ignored_loads++;
            return;
        end
        if (rec_cnt >= STORE_CAP)
        begin
            overflowed = 1;
            return;
        end
        used = (distinct_cnt < PALETTE_LIMIT) ? distinct_cnt : PALETTE_LIMIT;
        hit  = 0;
        slot = 0;
        for (int i = 0; i < used; i++)
        begin
            if (!hit && palette_mem[i] == w)
            begin
                slot = i;
                hit  = 1;
            end
        end
        if (!hit)
        begin
            if (distinct_cnt < PALETTE_LIMIT)
            begin
                palette_mem[distinct_cnt] = w;
                slot = distinct_cnt;
                distinct_cnt++;
            end
            else
                distinct_cnt = PALETTE_LIMIT + 1;
        end
        word_mem[rec_cnt]  = w;
        index_mem[rec_cnt] = slot[IDX_W-1:0];
        rec_cnt++;
        if (w[P95_BIT])
            p95_mem[p95_cnt++] = p95;
        if (w[SUP_BIT] && !w[UNIT_BIT])
            support_mem[support_cnt++] = sup;
        if (w[BND_BIT])
            bound_mem[bound_cnt++] = bnd;
    endfunction

    function automatic tile_beat_t next_tile_beat();
        tile_beat_t  r;
        logic [1:0]  st;
        int unsigned len;
        if (!streaming)
        begin
            st = ST_OK;
            if (overflowed)
                st = ST_OVERFLOW;
            else if (reg_w == 0 || reg_h == 0 || rec_cnt != 32'(reg_w) * 32'(reg_h) * 3)
                st = ST_COUNT;
            if (st != ST_OK)
            begin
                r = '{data: 8'd0, last: 1'b1, status: st, mode: MODE_UNIFORM};
                errors_seen++;
                clear_shadow_tile();
                return r;
            end
            streaming = 1;
            emit_pos  = 0;
        end
        len      = tile_stream_len();
        r.data   = tile_stream_byte(emit_pos);
        r.status = ST_OK;
        r.mode   = shadow_mode();
        if (emit_pos + 1 >= len)
        begin
            r.last = 1'b1;
            tiles_done++;
            clear_shadow_tile();
        end
        else
        begin
            r.last = 1'b0;
            emit_pos++;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus side
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Offer one beat, hold it until accepted, then update the shadow model.
    task automatic send_item(input logic op, input logic [WORD_W-1:0] w,
                             input logic [31:0] p95, input logic [31:0] sup,
                             input logic [31:0] bnd, output logic last);
        tile_beat_t r;
        int         gap;
        in_bus.valid        <= 1'b1;
        in_bus.opcode       <= op;
        in_bus.class_word   <= w;
        in_bus.p95_bits     <= p95;
        in_bus.support_bits <= sup;
        in_bus.bound_bits   <= bnd;
        do
            @(posedge clk);
        while (!in_bus.ready);
        items_sent++;
        last = 1'b0;
        if (op == OP_LOAD)
            absorb_record(w, p95, sup, bnd);
        else
        begin
            r = next_tile_beat();
            last = r.last;
            expected_beats = {expected_beats, r};
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_word(input logic [WORD_W-1:0] w);
        logic last;
        send_item(OP_LOAD, w, $urandom, $urandom, $urandom, last);
    endtask

    // Pull bytes until the stream ends; optionally drop in loads that must be ignored.
    task automatic fetch_tile(input int stray_pct);
        logic last;
        logic dummy;
        do
        begin
            send_item(OP_FETCH, WORD_W'($urandom), $urandom, $urandom, $urandom, last);
            if (!last && $urandom_range(0, 99) < stray_pct)
                send_item(OP_LOAD, WORD_W'($urandom), $urandom, $urandom, $urandom, dummy);
        end
        while (!last);
    endtask

    // Load n records cycling through `distinct` different random words.
    task automatic load_set(input int n, input int distinct);
        logic [WORD_W-1:0] pool[$];
        logic [WORD_W-1:0] w;
        bit                dup;
        while (pool.size() < distinct)
        begin
            w = WORD_W'($urandom);
            dup = 0;
            foreach (pool[j])
                if (pool[j] == w)
                    dup = 1;
            if (!dup)
                pool = {pool, w};
        end
        for (int i = 0; i < n; i++)
            load_word(pool[i % distinct]);
    endtask

    // Drop valid, drain every expected beat, then let the pipe settle.
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_TILE_X: reg_x = value;
            REG_TILE_Y: reg_y = value;
            REG_TILE_W: reg_w = value[6:0];
            default:    reg_h = value[6:0];
        endcase
    endtask

    task automatic set_tile(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] w, input logic [31:0] h);
        wait_idle();
        write_reg(REG_TILE_X, x);
        write_reg(REG_TILE_Y, y);
        write_reg(REG_TILE_W, w);
        write_reg(REG_TILE_H, h);
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Empty tile at reset geometry, then uniform, two-bit and dense tiles.
    task automatic test_directed_modes();
        fetch_tile(0);
        set_tile(32'hffff_ffff, 32'h0, 1, 1);
        // Uniform with p95, bound and a support flag masked by unit support.
        load_word(25'h10e_0000);
        load_word(25'h10e_0000);
        load_word(25'h10e_0000);
        fetch_tile(20);
        // Uniform again, support sent because unit support is clear.
        load_word(25'h004_0000 | 25'h0_abcd);
        load_word(25'h004_0000 | 25'h0_abcd);
        load_word(25'h004_0000 | 25'h0_abcd);
        fetch_tile(0);
        set_tile(32'h0, 32'hffff_ffff, 1, 1);
        load_word(25'h000_0000);
        load_word(25'h1ff_ffff);
        load_word(25'h00e_0000);
        fetch_tile(0);
        // Palette runs full: 17 distinct words switch to dense.
        set_tile(32'h5, 32'h7, 1, 6);
        load_set(18, 17);
        fetch_tile(0);
    endtask

    // Record count mismatches, a zero width and a zero height.
    task automatic test_count_errors();
        set_tile(32'h1, 32'h2, 1, 1);
        load_set(2, 2);
        fetch_tile(0);
        load_set(4, 1);
        fetch_tile(0);
        set_tile(32'h1, 32'h2, 0, 1);
        fetch_tile(0);
        set_tile(32'h1, 32'h2, 1, 0);
        load_set(3, 1);
        fetch_tile(0);
        set_tile(32'h1, 32'h2, 127, 127);
        load_set(3, 2);
        fetch_tile(0);
    endtask

    // Receiver holds off while fetches keep coming, stalling the input.
    task automatic test_backpressure();
        set_tile($urandom, $urandom, 2, 1);
        load_set(6, 5);
        no_gaps  = 1;
        hold_req = 1;
        fetch_tile(0);
        no_gaps = 0;
    endtask

    // Random tiles: mostly well-formed with random content, some with bad counts.
    task automatic test_random_tiles(input int item_goal);
        int w, h, n, distinct, roll;
        while (items_sent < item_goal)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
            h = $urandom_range(1, 4);
            set_tile($urandom, $urandom, w, h);
            n = w * h * 3;
            roll = $urandom_range(0, 99);
            if (roll < 8)
                n = n + $urandom_range(1, 3);
            else if (roll < 15)
                n = $urandom_range(0, n - 1);
            case ($urandom_range(0, 3))
                0: distinct = 1;
                1: distinct = $urandom_range(2, 4);
                2: distinct = $urandom_range(5, 16);
                default: distinct = $urandom_range(17, 24);
            endcase
            if (n > 0)
                load_set(n, (distinct > n) ? n : distinct);
            fetch_tile(5);
        end
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------

    // Random ready with occasional long holds, plus a long hold whenever one is requested.
    initial
    begin
        out_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                stall_count++;
                out_bus.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            else if ($urandom_range(0, 199) == 0)
            begin
                out_bus.ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
            else
                out_bus.ready <= ($urandom_range(0, 99) < 75);
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        tile_beat_t e;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected beat byte=%02h last=%0b status=%0d mode=%0d",
                         $time, out_bus.out_byte, out_bus.last_byte, out_bus.status,
                         out_bus.mode);
            end
            else
            begin
                e = expected_beats.pop_front();
                if (out_bus.out_byte !== e.data)
                begin
                    fail_count++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, e.data, out_bus.out_byte);
                end
                if (out_bus.last_byte !== e.last)
                begin
                    fail_count++;
                    $display("%0t: last_byte expected %0b actual %0b",
                             $time, e.last, out_bus.last_byte);
                end
                if (out_bus.status !== e.status)
                begin
                    fail_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.status, out_bus.status);
                end
                if (out_bus.mode !== e.mode)
                begin
                    fail_count++;
                    $display("%0t: mode expected %0d actual %0d",
                             $time, e.mode, out_bus.mode);
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d beats outstanding",
                     $time, IDLE_LIMIT, expected_beats.size());
            $display("palette_tile_metadata_encoder_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_TILE_X;
        cfg_data            <= '0;
        in_bus.valid        <= 1'b0;
        in_bus.opcode       <= OP_LOAD;
        in_bus.class_word   <= '0;
        in_bus.p95_bits     <= '0;
        in_bus.support_bits <= '0;
        in_bus.bound_bits   <= '0;
        fail_count    = 0;
        beats_checked = 0;
        tiles_done    = 0;
        errors_seen   = 0;
        ignored_loads = 0;
        stall_count   = 0;
        items_sent    = 0;
        hold_req      = 0;
        no_gaps       = 0;
        reg_x = 32'h0;
        reg_y = 32'h0;
        reg_w = 7'd64;
        reg_h = 7'd64;
        clear_shadow_tile();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_modes();
        test_count_errors();
        test_backpressure();
        test_random_tiles(650);

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Covered %0d streamed tiles and %0d error beats, %0d result beats checked.",
                 tiles_done, errors_seen, beats_checked);
        $display("Input beats sent: %0d, loads ignored mid-stream: %0d, long holds: %0d.",
                 items_sent, ignored_loads, stall_count);
        if (fail_count == 0)
            $display("palette_tile_metadata_encoder_unit verification clean");
        else
            $display("palette_tile_metadata_encoder_unit verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/ptme_pkg.sv
design/ptme_if.sv
design/ptme_ctrl.sv
design/ptme_datapath.sv
design/palette_tile_metadata_encoder_unit.sv
tb/tb_top.sv
